@@ src/stereo_linear_resampler_defines.svh @@
// ----------------------------------------------------------------------------
// Stereo linear resampler assertion macros
// Shared helpers for the concurrent checks on the resampler ports.
// ----------------------------------------------------------------------------
`ifndef STEREO_LINEAR_RESAMPLER_DEFINES_SVH
`define STEREO_LINEAR_RESAMPLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/slr_pkg.sv @@
// ----------------------------------------------------------------------------
// Stereo linear resampler package
// Types and fixed constants shared by the resampler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int STEP_W = 23;
   localparam int PHASE_W = 23;
   localparam int MAX_RESULTS = 64;
   localparam int CNT_W = 7;
   localparam int QUEUE_ADDR_W = 2;
   localparam logic [STEP_W-1:0] STEP_RESET = 23'd65536;

   typedef struct packed {
      logic                       first;
      logic signed [SAMPLE_W-1:0] right;
      logic signed [SAMPLE_W-1:0] left;
   } frame_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ src/slr_front.sv @@
// ----------------------------------------------------------------------------
// Resampler front end
// Accepts source frames and marks the first frame after reset as store-only.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [2*slr_pkg::SAMPLE_W-1:0] req_tdata,
   input  wire slr_pkg::queue_status_type   queue_status,
   output logic                             push,
   output slr_pkg::frame_type               push_frame
);

   logic have_prev_ff;

   assign req_tready = !queue_status.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_frame.first = !have_prev_ff;
      push_frame.left  = req_tdata[slr_pkg::SAMPLE_W-1:0];
      push_frame.right = req_tdata[2*slr_pkg::SAMPLE_W-1:slr_pkg::SAMPLE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else if (push) begin
         have_prev_ff <= 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ src/slr_queue.sv @@
// ----------------------------------------------------------------------------
// Resampler frame queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire slr_pkg::frame_type        push_frame,
   input  wire logic                      pop,
   output slr_pkg::frame_type             pop_frame,
   output slr_pkg::queue_status_type      status
);

   localparam int AW = slr_pkg::QUEUE_ADDR_W;
   localparam int DEPTH = 1 << AW;

   slr_pkg::frame_type entry_ff [DEPTH];
   logic [AW:0] wr_ptr_ff;
   logic [AW:0] rd_ptr_ff;

   always_comb begin
      status.empty = (wr_ptr_ff == rd_ptr_ff);
      status.full  = (wr_ptr_ff[AW] != rd_ptr_ff[AW]) &&
                     (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]);
   end

   assign pop_frame = entry_ff[rd_ptr_ff[AW-1:0]];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff[AW-1:0]] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

@@ src/slr_back.sv @@
// ----------------------------------------------------------------------------
// Resampler back end
// Steps the phase over each frame and interpolates both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_back #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [slr_pkg::STEP_W-1:0]    csr_data,
   input  wire slr_pkg::queue_status_type     queue_status,
   input  wire slr_pkg::frame_type            pop_frame,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [2*slr_pkg::SAMPLE_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int SW = slr_pkg::SAMPLE_W;
   localparam int PW = slr_pkg::PHASE_W;
   localparam int CW = slr_pkg::CNT_W;
   localparam int EXT_W = (FRAC_BITS + 1 > PW) ? FRAC_BITS + 1 : PW;
   localparam int PROD_W = SW + FRAC_BITS + 2;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   localparam logic [EXT_W-1:0]        ONE_EXT = EXT_W'(1) << FRAC_BITS;
   localparam logic signed [PROD_W-1:0] BIAS = PROD_W'((64'd1 << FRAC_BITS) - 64'd1);

   logic                   state_ff;
   logic [slr_pkg::STEP_W-1:0] step_ff;
   logic [PW-1:0]          phase_ff;
   logic [CW-1:0]          count_ff;
   logic signed [SW-1:0]   prev_l_ff;
   logic signed [SW-1:0]   prev_r_ff;
   logic signed [SW-1:0]   cur_l_ff;
   logic signed [SW-1:0]   cur_r_ff;

   logic                   b_valid_ff;
   logic                   b_last_ff;
   logic signed [SW-1:0]   b_base_l_ff;
   logic signed [SW-1:0]   b_base_r_ff;
   logic signed [PROD_W-1:0] b_prod_l_ff;
   logic signed [PROD_W-1:0] b_prod_r_ff;

   logic                   o_valid_ff;
   logic                   o_last_ff;
   logic [SW-1:0]          o_left_ff;
   logic [SW-1:0]          o_right_ff;

   logic [EXT_W-1:0]       phase_ext;
   logic                   ge_one;
   logic                   done;
   logic                   advance;
   logic                   issue;
   logic [PW:0]            phase_sum;
   logic [PW-1:0]          phase_in;
   logic                   last_in;
   logic signed [FRAC_BITS:0] frac_s;
   logic signed [SW:0]     diff_l;
   logic signed [SW:0]     diff_r;
   logic signed [PROD_W-1:0] prod_l_in;
   logic signed [PROD_W-1:0] prod_r_in;
   logic signed [PROD_W-1:0] num_l;
   logic signed [PROD_W-1:0] num_r;
   logic signed [PROD_W-1:0] quot_l;
   logic signed [PROD_W-1:0] quot_r;

   assign phase_ext = EXT_W'(phase_ff);
   assign ge_one    = (phase_ext >= ONE_EXT);
   assign done      = ge_one || (count_ff == CW'(slr_pkg::MAX_RESULTS));
   assign advance   = !o_valid_ff || rsp_tready;
   assign issue     = (state_ff == ST_RUN) && !done && advance;
   assign pop       = (state_ff == ST_IDLE) && !queue_status.empty;

   // The phase saturates at all ones rather than wrapping.
   always_comb begin
      phase_sum = {1'b0, phase_ff} + {1'b0, step_ff};
      phase_in  = phase_sum[PW] ? '1 : phase_sum[PW-1:0];
      last_in   = (EXT_W'(phase_in) >= ONE_EXT) ||
                  (count_ff == CW'(slr_pkg::MAX_RESULTS - 1));
   end

   // prev*(1-f) + cur*f is formed as prev*one + (cur-prev)*f.
   always_comb begin
      frac_s    = $signed({1'b0, phase_ext[FRAC_BITS-1:0]});
      diff_l    = $signed({cur_l_ff[SW-1], cur_l_ff}) - $signed({prev_l_ff[SW-1], prev_l_ff});
      diff_r    = $signed({cur_r_ff[SW-1], cur_r_ff}) - $signed({prev_r_ff[SW-1], prev_r_ff});
      prod_l_in = PROD_W'(diff_l) * PROD_W'(frac_s);
      prod_r_in = PROD_W'(diff_r) * PROD_W'(frac_s);
   end

   // Division by one truncates toward zero, so negative sums get a bias first.
   always_comb begin
      num_l  = (PROD_W'(b_base_l_ff) <<< FRAC_BITS) + b_prod_l_ff;
      num_r  = (PROD_W'(b_base_r_ff) <<< FRAC_BITS) + b_prod_r_ff;
      quot_l = (num_l[PROD_W-1] ? num_l + BIAS : num_l) >>> FRAC_BITS;
      quot_r = (num_r[PROD_W-1] ? num_r + BIAS : num_r) >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= slr_pkg::STEP_RESET;
         phase_ff  <= '0;
         count_ff  <= '0;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
      end else begin
         if (csr_valid) begin
            step_ff <= csr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (pop_frame.first) begin
                     prev_l_ff <= pop_frame.left;
                     prev_r_ff <= pop_frame.right;
                  end else begin
                     cur_l_ff <= pop_frame.left;
                     cur_r_ff <= pop_frame.right;
                     count_ff <= '0;
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               if (done) begin
                  phase_ff  <= ge_one ? PW'(phase_ext - ONE_EXT) : '0;
                  prev_l_ff <= cur_l_ff;
                  prev_r_ff <= cur_r_ff;
                  state_ff  <= ST_IDLE;
               end else if (issue) begin
                  phase_ff <= phase_in;
                  count_ff <= count_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= issue;
         o_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_last_ff   <= last_in;
         b_base_l_ff <= prev_l_ff;
         b_base_r_ff <= prev_r_ff;
         b_prod_l_ff <= prod_l_in;
         b_prod_r_ff <= prod_r_in;
         o_last_ff   <= b_last_ff;
         o_left_ff   <= quot_l[SW-1:0];
         o_right_ff  <= quot_r[SW-1:0];
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {o_right_ff, o_left_ff};

endmodule

`default_nettype wire

@@ src/stereo_linear_resampler.sv @@
// ----------------------------------------------------------------------------
// Stereo linear resampler
// Converts 16-bit stereo frames to another rate by linear interpolation.
// ----------------------------------------------------------------------------
// Frames enter on the req_ stream (left in the low half of tdata, right in
// the high half) and interpolated frames leave on the rsp_ stream in the same
// layout, with tlast on the final result that a source frame causes. The
// step ratio (source rate over output rate, unsigned with FRAC_BITS fraction
// bits) is written on the csr_ channel, which is always ready; write it only
// while the block is idle. The first frame after reset is only stored.
// A four-entry queue takes frames while the back end works. The back end
// loads a frame, issues its results and then closes the frame, and it takes
// the next frame from the queue only after that close. The first result of
// a frame passes from the RUN state through the b_ and o_ pipeline registers
// to rsp_tvalid, and the results follow one per cycle while rsp_tready stays
// high. When the receiver stalls, the two-stage interpolation pipeline holds
// and the queue fills, after which req_tready drops. Reset empties the queue
// and the pipeline, clears the phase and the stored frame, and sets the step
// to 65536, which is 1.0 at the default FRAC_BITS of 16.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_linear_resampler #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // in_left [15:0], in_right [31:16]
   input  wire logic [2*slr_pkg::SAMPLE_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // out_left [15:0], out_right [31:16]
   output logic [2*slr_pkg::SAMPLE_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [slr_pkg::STEP_W-1:0]     csr_data
);

   slr_pkg::queue_status_type queue_status;
   slr_pkg::frame_type        push_frame;
   slr_pkg::frame_type        pop_frame;
   logic                      push;
   logic                      pop;

   assign csr_ready = 1'b1;

   slr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .queue_status (queue_status),
      .push         (push),
      .push_frame   (push_frame)
   );

   slr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .pop_frame  (pop_frame),
      .status     (queue_status)
   );

   slr_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .queue_status (queue_status),
      .pop_frame    (pop_frame),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ src/slr_checker.sv @@
// ----------------------------------------------------------------------------
// Resampler port checker
// Concurrent checks on the resampler ports, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_linear_resampler_defines.svh"

module slr_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [2*slr_pkg::SAMPLE_W-1:0] rsp_tdata,
   input wire logic                           rsp_tlast
);

   // Counts accepted requests, saturating at two.
   logic [1:0] seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (req_tvalid && req_tready && (seen_ff != 2'd2)) begin
         seen_ff <= seen_ff + 1'b1;
      end
   end

   `SLR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "stalled result changed")
   `SLR_ASSERT_NOW(a_quiet_after_reset, $fell(reset), !rsp_tvalid,
      "result present right after reset")
   `SLR_ASSERT_NOW(a_two_frames_first, rsp_tvalid, seen_ff == 2'd2,
      "result before two frames were accepted")

endmodule

bind stereo_linear_resampler slr_checker u_slr_checker (.*);

`default_nettype wire
